// ----- hw/rtl/stkr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stkr_pkg
// Shared types and constants of the sorted-table key range lookup core.
// ----------------------------------------------------------------------------
package stkr_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 4096;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int POS_W       = $clog2(TABLE_DEPTH + 1);
   localparam int MAX_EMIT    = 64;
   localparam int EMIT_W      = $clog2(MAX_EMIT + 1);

   // field widths
   localparam int KEY_W    = 64;
   localparam int MOVE_W   = 16;
   localparam int WEIGHT_W = 16;
   localparam int LEARN_W  = 32;
   localparam int INDEX_W  = 12;
   localparam int STATUS_W = 2;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;
   localparam int SIZE_W      = 13;
   localparam int CAP_W       = 7;

   localparam logic [CSR_INDEX_W-1:0] REG_TABLE_SIZE = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_RESULT_CAP = CSR_INDEX_W'(1);

   localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = SIZE_W'(1);
   localparam logic [CAP_W-1:0]  RESULT_CAP_RESET = CAP_W'(64);

   // input commands
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_WRITE   = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] STATUS_MATCH   = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] STATUS_NOMATCH = STATUS_W'(2);

   typedef struct packed {
      logic [KEY_W-1:0]    key;
      logic [MOVE_W-1:0]   move;
      logic [WEIGHT_W-1:0] weight;
      logic [LEARN_W-1:0]  learn;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PROBE,
      ST_CMP,
      ST_TAIL,
      ST_BACK_RD,
      ST_BACK_CMP,
      ST_FWD_RD,
      ST_FWD_CMP,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      RD_MID,
      RD_HIGH,
      RD_PREV,
      RD_POS
   } rd_sel_type;

   typedef struct packed {
      logic       write_en;
      logic       push_write;
      logic       accept_query;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       load_mid;
      logic       set_high_mid;
      logic       set_low_mid;
      logic       set_pos_mid;
      logic       set_pos_high;
      logic       dec_pos;
      logic       inc_pos;
      logic       emit;
      logic       push_final;
   } cmd_type;

   typedef struct packed {
      logic query_trivial;
      logic key_eq;
      logic key_gt;
      logic mid_gt_low;
      logic span_wide;
      logic high_ge_size;
      logic pos_zero;
      logic fwd_done;
      logic entry_live;
      logic pend_valid;
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

// ----- hw/rtl/sorted_table_key_range_lookup_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_table_key_range_lookup_core
// Sorted 64-bit key table with binary search and equal-key run output.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item: a write (req_command = 0) loads an entry at
//   req_entry_index; a query (req_command = 1) looks up req_query_key.
//   rsp_* returns results; rsp_last marks the final result of an item.
//   A write answers with one status-write result. A query answers with
//   one result per live match, in table order up to result_cap, or one no-match.
//   csr_* writes table_size (index 0) and result_cap (index 1); write only
//   while the core is idle. csr_ready is always high.
// Sequence:
//   A write result is registered in the cycle after acceptance. A query
//   makes binary-search probes, each a registered read of the entry
//   memory, then steps backwards over equal keys, walks the run, and ends
//   with the final result. One item is in work at a time.
// Reset clears the controller, the output register and the configuration
// (table_size = 1, result_cap = 64); table contents stay undefined until
// written. A stalled rsp_ready holds the output register and the walker.
// ----------------------------------------------------------------------------
module sorted_table_key_range_lookup_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_command,
   input  wire logic [stkr_pkg::INDEX_W-1:0]     req_entry_index,
   input  wire logic [stkr_pkg::KEY_W-1:0]       req_entry_key,
   input  wire logic [stkr_pkg::MOVE_W-1:0]      req_entry_move,
   input  wire logic [stkr_pkg::WEIGHT_W-1:0]    req_entry_weight,
   input  wire logic [stkr_pkg::LEARN_W-1:0]     req_entry_learn,
   input  wire logic [stkr_pkg::KEY_W-1:0]       req_query_key,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [stkr_pkg::STATUS_W-1:0]         rsp_status,
   output logic [stkr_pkg::MOVE_W-1:0]           rsp_match_move,
   output logic [stkr_pkg::WEIGHT_W-1:0]         rsp_match_weight,
   output logic [stkr_pkg::LEARN_W-1:0]          rsp_match_learn,
   output logic [stkr_pkg::INDEX_W-1:0]          rsp_match_index,
   output logic                                  rsp_last,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [stkr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [stkr_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   stkr_pkg::cmd_type cmd;
   stkr_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   stkr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .sts         (sts),
      .cmd         (cmd)
   );

   stkr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_entry_index  (req_entry_index),
      .req_entry_key    (req_entry_key),
      .req_entry_move   (req_entry_move),
      .req_entry_weight (req_entry_weight),
      .req_entry_learn  (req_entry_learn),
      .req_query_key    (req_query_key),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_match_move   (rsp_match_move),
      .rsp_match_weight (rsp_match_weight),
      .rsp_match_learn  (rsp_match_learn),
      .rsp_match_index  (rsp_match_index),
      .rsp_last         (rsp_last)
   );

endmodule
`default_nettype wire

// ----- hw/rtl/stkr_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stkr_ctrl
// Sequencer: handshake on the request side, binary search, back-up over
// equal keys, forward walk over the run, and final result.
// ----------------------------------------------------------------------------
module stkr_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_command,
   output logic                  req_ready,
   input  wire stkr_pkg::sts_type sts,
   output stkr_pkg::cmd_type     cmd
);

   stkr_pkg::state_type state_ff;
   stkr_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stkr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.rd_sel = stkr_pkg::RD_MID;
      req_ready = 1'b0;
      unique case (state_ff)
         stkr_pkg::ST_IDLE: begin
            req_ready = sts.out_free;
            if (req_valid && sts.out_free) begin
               if (req_command == stkr_pkg::CMD_WRITE) begin
                  cmd.write_en   = 1'b1;
                  cmd.push_write = 1'b1;
               end else begin
                  cmd.accept_query = 1'b1;
                  state_in = sts.query_trivial ? stkr_pkg::ST_FINISH : stkr_pkg::ST_PROBE;
               end
            end
         end
         stkr_pkg::ST_PROBE: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = stkr_pkg::RD_MID;
            cmd.load_mid = 1'b1;
            state_in     = stkr_pkg::ST_CMP;
         end
         stkr_pkg::ST_CMP: begin
            priority if (sts.key_eq) begin
               cmd.set_pos_mid = 1'b1;
               state_in = stkr_pkg::ST_BACK_RD;
            end else if (sts.key_gt) begin
               cmd.set_high_mid = 1'b1;
               state_in = sts.mid_gt_low ? stkr_pkg::ST_PROBE : stkr_pkg::ST_FINISH;
            end else if (sts.span_wide) begin
               cmd.set_low_mid = 1'b1;
               state_in = stkr_pkg::ST_PROBE;
            end else if (sts.high_ge_size) begin
               state_in = stkr_pkg::ST_FINISH;
            end else begin
               // narrowed to one slot below the key: look just past it
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = stkr_pkg::RD_HIGH;
               state_in   = stkr_pkg::ST_TAIL;
            end
         end
         stkr_pkg::ST_TAIL: begin
            if (sts.key_eq) begin
               cmd.set_pos_high = 1'b1;
               state_in = stkr_pkg::ST_BACK_RD;
            end else begin
               state_in = stkr_pkg::ST_FINISH;
            end
         end
         stkr_pkg::ST_BACK_RD: begin
            if (sts.pos_zero) begin
               state_in = stkr_pkg::ST_FWD_RD;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = stkr_pkg::RD_PREV;
               state_in   = stkr_pkg::ST_BACK_CMP;
            end
         end
         stkr_pkg::ST_BACK_CMP: begin
            if (sts.key_eq) begin
               cmd.dec_pos = 1'b1;
               state_in = stkr_pkg::ST_BACK_RD;
            end else begin
               state_in = stkr_pkg::ST_FWD_RD;
            end
         end
         stkr_pkg::ST_FWD_RD: begin
            if (sts.fwd_done) begin
               state_in = stkr_pkg::ST_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = stkr_pkg::RD_POS;
               state_in   = stkr_pkg::ST_FWD_CMP;
            end
         end
         stkr_pkg::ST_FWD_CMP: begin
            priority if (!sts.key_eq) begin
               state_in = stkr_pkg::ST_FINISH;
            end else if (sts.entry_live && sts.pend_valid && !sts.out_free) begin
               // hold until the output register frees up
               state_in = stkr_pkg::ST_FWD_CMP;
            end else begin
               cmd.emit    = sts.entry_live;
               cmd.inc_pos = 1'b1;
               state_in    = stkr_pkg::ST_FWD_RD;
            end
         end
         stkr_pkg::ST_FINISH: begin
            if (sts.out_free) begin
               cmd.push_final = 1'b1;
               state_in = stkr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = stkr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- hw/rtl/stkr_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stkr_datapath
// Entry memory, search bounds, run walker, pending match and output register,
// plus the two configuration registers.
// ----------------------------------------------------------------------------
module stkr_datapath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire stkr_pkg::cmd_type                cmd,
   output stkr_pkg::sts_type                     sts,
   input  wire logic                             csr_valid,
   input  wire logic [stkr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [stkr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic [stkr_pkg::INDEX_W-1:0]     req_entry_index,
   input  wire logic [stkr_pkg::KEY_W-1:0]       req_entry_key,
   input  wire logic [stkr_pkg::MOVE_W-1:0]      req_entry_move,
   input  wire logic [stkr_pkg::WEIGHT_W-1:0]    req_entry_weight,
   input  wire logic [stkr_pkg::LEARN_W-1:0]     req_entry_learn,
   input  wire logic [stkr_pkg::KEY_W-1:0]       req_query_key,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_valid,
   output logic [stkr_pkg::STATUS_W-1:0]         rsp_status,
   output logic [stkr_pkg::MOVE_W-1:0]           rsp_match_move,
   output logic [stkr_pkg::WEIGHT_W-1:0]         rsp_match_weight,
   output logic [stkr_pkg::LEARN_W-1:0]          rsp_match_learn,
   output logic [stkr_pkg::INDEX_W-1:0]          rsp_match_index,
   output logic                                  rsp_last
);

   localparam int POS_W  = stkr_pkg::POS_W;
   localparam int ADDR_W = stkr_pkg::ADDR_W;
   localparam int EMIT_W = stkr_pkg::EMIT_W;

   stkr_pkg::entry_type table_mem [stkr_pkg::TABLE_DEPTH];
   stkr_pkg::entry_type rd_entry_ff;

   logic [stkr_pkg::SIZE_W-1:0] table_size_ff, table_size_in;
   logic [stkr_pkg::CAP_W-1:0]  result_cap_ff, result_cap_in;

   logic [stkr_pkg::KEY_W-1:0] key_ff, key_in;
   logic [POS_W-1:0]  size_ff, size_in;
   logic [EMIT_W-1:0] cap_ff, cap_in;
   logic [POS_W-1:0]  low_ff, low_in;
   logic [POS_W-1:0]  high_ff, high_in;
   logic [POS_W-1:0]  mid_ff, mid_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [EMIT_W-1:0] emitted_ff, emitted_in;

   logic                             pend_valid_ff, pend_valid_in;
   logic [stkr_pkg::MOVE_W-1:0]      pend_move_ff, pend_move_in;
   logic [stkr_pkg::WEIGHT_W-1:0]    pend_weight_ff, pend_weight_in;
   logic [stkr_pkg::LEARN_W-1:0]     pend_learn_ff, pend_learn_in;
   logic [stkr_pkg::INDEX_W-1:0]     pend_index_ff, pend_index_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [stkr_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [stkr_pkg::MOVE_W-1:0]      rsp_move_ff, rsp_move_in;
   logic [stkr_pkg::WEIGHT_W-1:0]    rsp_weight_ff, rsp_weight_in;
   logic [stkr_pkg::LEARN_W-1:0]     rsp_learn_ff, rsp_learn_in;
   logic [stkr_pkg::INDEX_W-1:0]     rsp_index_ff, rsp_index_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic [POS_W-1:0]  size_eff;
   logic [EMIT_W-1:0] cap_eff;
   logic [POS_W:0]    bound_sum;
   logic [POS_W-1:0]  mid_calc;
   logic [POS_W-1:0]  rd_pos;
   logic [ADDR_W-1:0] rd_addr;
   logic              write_ok;
   logic              out_free;
   logic              push;

   // saturate the configured limits
   assign size_eff = (table_size_ff > stkr_pkg::SIZE_W'(stkr_pkg::TABLE_DEPTH))
                     ? POS_W'(stkr_pkg::TABLE_DEPTH) : POS_W'(table_size_ff);
   assign cap_eff  = (result_cap_ff > stkr_pkg::CAP_W'(stkr_pkg::MAX_EMIT))
                     ? EMIT_W'(stkr_pkg::MAX_EMIT) : EMIT_W'(result_cap_ff);

   assign bound_sum = {1'b0, low_ff} + {1'b0, high_ff};
   assign mid_calc  = bound_sum[POS_W:1];

   always_comb begin
      unique case (cmd.rd_sel)
         stkr_pkg::RD_MID:  rd_pos = mid_calc;
         stkr_pkg::RD_HIGH: rd_pos = high_ff;
         stkr_pkg::RD_PREV: rd_pos = pos_ff - POS_W'(1);
         stkr_pkg::RD_POS:  rd_pos = pos_ff;
         default:           rd_pos = pos_ff;
      endcase
   end
   assign rd_addr  = rd_pos[ADDR_W-1:0];
   assign write_ok = (POS_W'(req_entry_index) < POS_W'(stkr_pkg::TABLE_DEPTH));

   always_ff @(posedge clock) begin
      if (cmd.write_en && write_ok) begin
         table_mem[req_entry_index[ADDR_W-1:0]] <= {req_entry_key, req_entry_move,
                                                   req_entry_weight, req_entry_learn};
      end
      if (cmd.rd_en) begin
         rd_entry_ff <= table_mem[rd_addr];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign push     = cmd.push_write || cmd.push_final || (cmd.emit && pend_valid_ff);

   always_comb begin
      sts.query_trivial = (req_query_key == '0) || (cap_eff == '0) || (size_eff == '0);
      sts.key_eq        = (rd_entry_ff.key == key_ff);
      sts.key_gt        = (rd_entry_ff.key > key_ff);
      sts.mid_gt_low    = (mid_ff > low_ff);
      sts.span_wide     = ({1'b0, high_ff} > ({1'b0, low_ff} + (POS_W + 1)'(1)));
      sts.high_ge_size  = (high_ff >= size_ff);
      sts.pos_zero      = (pos_ff == '0);
      sts.fwd_done      = (emitted_ff >= cap_ff) || (pos_ff >= size_ff);
      sts.entry_live    = (rd_entry_ff.weight != '0) && (rd_entry_ff.move != '0);
      sts.pend_valid    = pend_valid_ff;
      sts.out_free      = out_free;
   end

   // configuration registers
   always_comb begin
      table_size_in = table_size_ff;
      result_cap_in = result_cap_ff;
      if (csr_valid) begin
         unique case (csr_index)
            stkr_pkg::REG_TABLE_SIZE: table_size_in = csr_wdata[stkr_pkg::SIZE_W-1:0];
            stkr_pkg::REG_RESULT_CAP: result_cap_in = csr_wdata[stkr_pkg::CAP_W-1:0];
            default: ;
         endcase
      end
   end

   // search bounds and run walker
   always_comb begin
      key_in  = key_ff;
      size_in = size_ff;
      cap_in  = cap_ff;
      low_in  = low_ff;
      high_in = high_ff;
      mid_in  = mid_ff;
      pos_in  = pos_ff;
      if (cmd.accept_query) begin
         key_in  = req_query_key;
         size_in = size_eff;
         cap_in  = cap_eff;
         low_in  = '0;
         high_in = size_eff;
      end
      if (cmd.load_mid)     mid_in  = mid_calc;
      if (cmd.set_high_mid) high_in = mid_ff;
      if (cmd.set_low_mid)  low_in  = mid_ff;
      if (cmd.set_pos_mid)  pos_in  = mid_ff;
      if (cmd.set_pos_high) pos_in  = high_ff;
      if (cmd.dec_pos)      pos_in  = pos_ff - POS_W'(1);
      if (cmd.inc_pos)      pos_in  = pos_ff + POS_W'(1);
   end

   // pending match and emitted count
   always_comb begin
      pend_valid_in  = pend_valid_ff;
      pend_move_in   = pend_move_ff;
      pend_weight_in = pend_weight_ff;
      pend_learn_in  = pend_learn_ff;
      pend_index_in  = pend_index_ff;
      emitted_in     = emitted_ff;
      if (cmd.accept_query || cmd.push_final) begin
         pend_valid_in = 1'b0;
      end
      if (cmd.accept_query) begin
         emitted_in = '0;
      end
      if (cmd.emit) begin
         pend_valid_in  = 1'b1;
         pend_move_in   = rd_entry_ff.move;
         pend_weight_in = rd_entry_ff.weight;
         pend_learn_in  = rd_entry_ff.learn;
         pend_index_in  = stkr_pkg::INDEX_W'(pos_ff);
         emitted_in     = emitted_ff + EMIT_W'(1);
      end
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_move_in   = rsp_move_ff;
      rsp_weight_in = rsp_weight_ff;
      rsp_learn_in  = rsp_learn_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_last_in   = rsp_last_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (push) begin
         rsp_valid_in = 1'b1;
         priority if (cmd.push_write || (cmd.push_final && !pend_valid_ff)) begin
            rsp_status_in = cmd.push_write ? stkr_pkg::STATUS_WRITE
                                           : stkr_pkg::STATUS_NOMATCH;
            rsp_move_in   = '0;
            rsp_weight_in = '0;
            rsp_learn_in  = '0;
            rsp_index_in  = '0;
            rsp_last_in   = 1'b1;
         end else begin
            // flush the held match; it is final only at the end of the run
            rsp_status_in = stkr_pkg::STATUS_MATCH;
            rsp_move_in   = pend_move_ff;
            rsp_weight_in = pend_weight_ff;
            rsp_learn_in  = pend_learn_ff;
            rsp_index_in  = pend_index_ff;
            rsp_last_in   = cmd.push_final;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= stkr_pkg::TABLE_SIZE_RESET;
         result_cap_ff <= stkr_pkg::RESULT_CAP_RESET;
         emitted_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         table_size_ff <= table_size_in;
         result_cap_ff <= result_cap_in;
         emitted_ff    <= emitted_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      size_ff        <= size_in;
      cap_ff         <= cap_in;
      low_ff         <= low_in;
      high_ff        <= high_in;
      mid_ff         <= mid_in;
      pos_ff         <= pos_in;
      pend_move_ff   <= pend_move_in;
      pend_weight_ff <= pend_weight_in;
      pend_learn_ff  <= pend_learn_in;
      pend_index_ff  <= pend_index_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_move_ff    <= rsp_move_in;
      rsp_weight_ff  <= rsp_weight_in;
      rsp_learn_ff   <= rsp_learn_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_match_move   = rsp_move_ff;
   assign rsp_match_weight = rsp_weight_ff;
   assign rsp_match_learn  = rsp_learn_ff;
   assign rsp_match_index  = rsp_index_ff;
   assign rsp_last         = rsp_last_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/stkr_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stkr_checker
// Port-level checks of the lookup core, bound to the top level.
// ----------------------------------------------------------------------------
module stkr_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_ready,
   input wire logic                             req_command,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [stkr_pkg::STATUS_W-1:0]    rsp_status,
   input wire logic [stkr_pkg::MOVE_W-1:0]      rsp_match_move,
   input wire logic [stkr_pkg::WEIGHT_W-1:0]    rsp_match_weight,
   input wire logic [stkr_pkg::LEARN_W-1:0]     rsp_match_learn,
   input wire logic [stkr_pkg::INDEX_W-1:0]     rsp_match_index,
   input wire logic                             rsp_last
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_last)
         && $stable(rsp_match_index))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == stkr_pkg::STATUS_WRITE)
         || (rsp_status == stkr_pkg::STATUS_MATCH)
         || (rsp_status == stkr_pkg::STATUS_NOMATCH))
      else $error("bad result status");

   // write and no-match results are single, final and zero-filled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != stkr_pkg::STATUS_MATCH) |-> rsp_last
         && (rsp_match_move == '0) && (rsp_match_weight == '0)
         && (rsp_match_learn == '0) && (rsp_match_index == '0))
      else $error("malformed write or no-match result");

   // a reported match is a live entry
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == stkr_pkg::STATUS_MATCH)
         |-> (rsp_match_move != '0) && (rsp_match_weight != '0))
      else $error("dead entry reported");

   // a write accepted with the output free answers on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_command == stkr_pkg::CMD_WRITE)
         |=> rsp_valid && (rsp_status == stkr_pkg::STATUS_WRITE) && rsp_last)
      else $error("write result missing");

endmodule

bind sorted_table_key_range_lookup_core stkr_checker u_stkr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_command      (req_command),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_match_move   (rsp_match_move),
   .rsp_match_weight (rsp_match_weight),
   .rsp_match_learn  (rsp_match_learn),
   .rsp_match_index  (rsp_match_index),
   .rsp_last         (rsp_last)
);
`default_nettype wire

// ----- tb/sv/tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted-table key range lookup core.
// Table writes and key queries go in on the req channel, and configuration
// writes go in on the csr channel while the core is idle. A shadow copy of
// the table and the registers predicts every result. Each rsp item is
// checked field by field against the oldest pending answer. The stimulus
// starts with directed cases: extremes, dead entries, capping, saturation
// and missed probes. Writes along the right-hand search path of a full-size
// table come next, then random phases that each reload a small sorted prefix
// and query it. Sender and receiver idle at random, and one long receiver
// stall backs up the input.
// ----------------------------------------------------------------------------
module tb;

   localparam int CLK_PERIOD     = 8;
   localparam int TIMEOUT_CYCLES = 1000000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int DRAIN_CYCLES   = 40;
   localparam int LONG_STALL     = 300;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_QUERIES  = 8;
   localparam int CAP_FIELD_MAX  = (1 << stkr_pkg::CAP_W) - 1;
   localparam int RUN_SPAN       = 70;
   localparam int SPINE_STEP     = 256;

   localparam logic [stkr_pkg::CSR_INDEX_W-1:0] REG_SPARE_2 = stkr_pkg::CSR_INDEX_W'(2);
   localparam logic [stkr_pkg::CSR_INDEX_W-1:0] REG_SPARE_3 = stkr_pkg::CSR_INDEX_W'(3);

   localparam logic [stkr_pkg::KEY_W-1:0] KEY_MAX = '1;

   typedef struct {
      logic                           cmd;
      logic [stkr_pkg::INDEX_W-1:0]   slot;
      logic [stkr_pkg::KEY_W-1:0]     key;
      logic [stkr_pkg::MOVE_W-1:0]    move;
      logic [stkr_pkg::WEIGHT_W-1:0]  weight;
      logic [stkr_pkg::LEARN_W-1:0]   learn;
      logic [stkr_pkg::KEY_W-1:0]     query_key;
   } table_cmd_type;

   typedef struct packed {
      logic [stkr_pkg::STATUS_W-1:0]  status;
      logic [stkr_pkg::MOVE_W-1:0]    move;
      logic [stkr_pkg::WEIGHT_W-1:0]  weight;
      logic [stkr_pkg::LEARN_W-1:0]   learn;
      logic [stkr_pkg::INDEX_W-1:0]   slot;
      logic                           last;
   } match_type;

   logic clock;
   logic reset = 1'b1;

   logic                                 req_valid        = 1'b0;
   logic                                 req_ready;
   logic                                 req_command      = stkr_pkg::CMD_WRITE;
   logic [stkr_pkg::INDEX_W-1:0]         req_entry_index  = '0;
   logic [stkr_pkg::KEY_W-1:0]           req_entry_key    = '0;
   logic [stkr_pkg::MOVE_W-1:0]          req_entry_move   = '0;
   logic [stkr_pkg::WEIGHT_W-1:0]        req_entry_weight = '0;
   logic [stkr_pkg::LEARN_W-1:0]         req_entry_learn  = '0;
   logic [stkr_pkg::KEY_W-1:0]           req_query_key    = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready        = 1'b0;
   logic [stkr_pkg::STATUS_W-1:0]        rsp_status;
   logic [stkr_pkg::MOVE_W-1:0]          rsp_match_move;
   logic [stkr_pkg::WEIGHT_W-1:0]        rsp_match_weight;
   logic [stkr_pkg::LEARN_W-1:0]         rsp_match_learn;
   logic [stkr_pkg::INDEX_W-1:0]         rsp_match_index;
   logic                                 rsp_last;
   logic                                 csr_valid        = 1'b0;
   logic                                 csr_ready;
   logic [stkr_pkg::CSR_INDEX_W-1:0]     csr_index        = '0;
   logic [stkr_pkg::CSR_DATA_W-1:0]      csr_wdata        = '0;

   sorted_table_key_range_lookup_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_entry_index  (req_entry_index),
      .req_entry_key    (req_entry_key),
      .req_entry_move   (req_entry_move),
      .req_entry_weight (req_entry_weight),
      .req_entry_learn  (req_entry_learn),
      .req_query_key    (req_query_key),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_match_move   (rsp_match_move),
      .rsp_match_weight (rsp_match_weight),
      .rsp_match_learn  (rsp_match_learn),
      .rsp_match_index  (rsp_match_index),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // shadow of the core
   stkr_pkg::entry_type         shadow_table [stkr_pkg::TABLE_DEPTH];
   logic [stkr_pkg::SIZE_W-1:0] cfg_table_size = stkr_pkg::TABLE_SIZE_RESET;
   logic [stkr_pkg::CAP_W-1:0]  cfg_result_cap = stkr_pkg::RESULT_CAP_RESET;
   match_type                   answer_fifo [$];

   // stimulus side
   table_cmd_type              cmd_backlog [$];
   logic [stkr_pkg::KEY_W-1:0] plan_key [stkr_pkg::TABLE_DEPTH];
   int                         items_queued   = 0;
   int                         items_accepted = 0;
   int                         send_idle_pct  = 26;
   int                         recv_idle_pct  = 58;
   int                         stall_asks     = 0;
   int                         stalls_taken   = 0;
   int                         stall_left     = 0;
   logic                       req_taken      = 1'b0;
   bit                         mismatch_seen  = 1'b0;

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(CLK_PERIOD * TIMEOUT_CYCLES);
      $display("Mismatches found");
      $finish;
   end

   // Expected answers of one query: binary search, back up to the first
   // equal key, then walk the run and keep live entries up to the cap.
   function automatic void find_key_run(input logic [stkr_pkg::KEY_W-1:0] key);
      int unsigned span_size, span_cap, lo, hi, mid, pos;
      bit          done, found;
      match_type   run [$];
      match_type   one;
      span_size = (cfg_table_size > stkr_pkg::TABLE_DEPTH) ? stkr_pkg::TABLE_DEPTH
                                                           : cfg_table_size;
      span_cap  = (cfg_result_cap > stkr_pkg::MAX_EMIT) ? stkr_pkg::MAX_EMIT
                                                        : cfg_result_cap;
      found = 1'b0;
      done  = 1'b0;
      lo    = 0;
      hi    = span_size;
      pos   = 0;
      if (key != '0 && span_cap != 0) begin
         while (!done && lo < hi) begin
            mid = (lo + hi) / 2;
            if (shadow_table[mid].key == key) begin
               pos   = mid;
               found = 1'b1;
               done  = 1'b1;
            end else if (shadow_table[mid].key > key) begin
               hi = mid;
            end else if (hi > lo + 1) begin
               lo = mid;
            end else begin
               // narrowed below the key: stop, after a look at the next slot if in the table
               done = 1'b1;
               if (hi < span_size && shadow_table[hi].key == key) begin
                  pos   = hi;
                  found = 1'b1;
               end
            end
         end
      end
      if (found) begin
         while (pos > 0 && shadow_table[pos - 1].key == key)
            pos--;
         while (run.size() < span_cap && pos < span_size && shadow_table[pos].key == key) begin
            if (shadow_table[pos].weight != '0 && shadow_table[pos].move != '0) begin
               one        = '0;
               one.status = stkr_pkg::STATUS_MATCH;
               one.move   = shadow_table[pos].move;
               one.weight = shadow_table[pos].weight;
               one.learn  = shadow_table[pos].learn;
               one.slot   = stkr_pkg::INDEX_W'(pos);
               run.push_back(one);
            end
            pos++;
         end
      end
      if (run.size() == 0) begin
         one        = '0;
         one.status = stkr_pkg::STATUS_NOMATCH;
         one.last   = 1'b1;
         run.push_back(one);
      end else begin
         run[run.size() - 1].last = 1'b1;
      end
      foreach (run[i])
         answer_fifo.push_back(run[i]);
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] seen);
      if (seen !== want) begin
         $error("%s: expected %0h, got %0h", name, want, seen);
         mismatch_seen = 1'b1;
      end
   endfunction

   always @(posedge clock) begin : scoreboard
      match_type want;
      match_type wr;
      req_taken <= req_valid && req_ready && !reset;
      if (reset) begin
         cfg_table_size = stkr_pkg::TABLE_SIZE_RESET;
         cfg_result_cap = stkr_pkg::RESULT_CAP_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               stkr_pkg::REG_TABLE_SIZE: cfg_table_size = csr_wdata[stkr_pkg::SIZE_W-1:0];
               stkr_pkg::REG_RESULT_CAP: cfg_result_cap = csr_wdata[stkr_pkg::CAP_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_command == stkr_pkg::CMD_WRITE) begin
               shadow_table[req_entry_index] = {req_entry_key, req_entry_move,
                                                req_entry_weight, req_entry_learn};
               wr        = '0;
               wr.status = stkr_pkg::STATUS_WRITE;
               wr.last   = 1'b1;
               answer_fifo.push_back(wr);
            end else begin
               find_key_run(req_query_key);
            end
            items_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (answer_fifo.size() == 0) begin
               $error("rsp item with no pending answer, status %0d", rsp_status);
               mismatch_seen = 1'b1;
            end else begin
               want = answer_fifo.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("match_move", want.move, rsp_match_move);
               check_field("match_weight", want.weight, rsp_match_weight);
               check_field("match_learn", want.learn, rsp_match_learn);
               check_field("match_index", want.slot, rsp_match_index);
               check_field("last", want.last, rsp_last);
            end
         end
      end
   end

   always @(negedge clock) begin : cmd_driver
      table_cmd_type next_cmd;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_cmd = cmd_backlog.pop_front();
            req_valid        <= 1'b1;
            req_command      <= next_cmd.cmd;
            req_entry_index  <= next_cmd.slot;
            req_entry_key    <= next_cmd.key;
            req_entry_move   <= next_cmd.move;
            req_entry_weight <= next_cmd.weight;
            req_entry_learn  <= next_cmd.learn;
            req_query_key    <= next_cmd.query_key;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (stall_asks != stalls_taken) begin
         // hold off long enough for the core to back up its input
         stalls_taken++;
         stall_left = LONG_STALL;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   task automatic queue_write(input int slot, input logic [stkr_pkg::KEY_W-1:0] key,
                              input logic [stkr_pkg::MOVE_W-1:0] move,
                              input logic [stkr_pkg::WEIGHT_W-1:0] weight,
                              input logic [stkr_pkg::LEARN_W-1:0] learn);
      table_cmd_type c;
      c.cmd       = stkr_pkg::CMD_WRITE;
      c.slot      = stkr_pkg::INDEX_W'(slot);
      c.key       = key;
      c.move      = move;
      c.weight    = weight;
      c.learn     = learn;
      c.query_key = {$urandom, $urandom};
      cmd_backlog.push_back(c);
      items_queued++;
   endtask

   task automatic queue_query(input logic [stkr_pkg::KEY_W-1:0] key);
      table_cmd_type c;
      c.cmd       = stkr_pkg::CMD_QUERY;
      c.slot      = stkr_pkg::INDEX_W'($urandom);
      c.key       = {$urandom, $urandom};
      c.move      = stkr_pkg::MOVE_W'($urandom);
      c.weight    = stkr_pkg::WEIGHT_W'($urandom);
      c.learn     = $urandom;
      c.query_key = key;
      cmd_backlog.push_back(c);
      items_queued++;
   endtask

   task automatic write_csr(input logic [stkr_pkg::CSR_INDEX_W-1:0] slot,
                            input logic [stkr_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= slot;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_pace(input int send_pct, input int recv_pct);
      @(posedge clock);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   task automatic wait_idle();
      while (items_accepted != items_queued || answer_fifo.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write slots 0..count-1 with non-descending keys; slots after run_from up to
   // run_from+run_len-1 repeat its key and stay live.
   task automatic load_sorted_prefix(input int count, input int dup_pct, input int step_bits,
                                     input int run_from, input int run_len);
      logic [stkr_pkg::KEY_W-1:0]    key;
      logic [stkr_pkg::MOVE_W-1:0]   mv;
      logic [stkr_pkg::WEIGHT_W-1:0] wt;
      bit                            in_run;
      key = {$urandom, $urandom} >> 4;
      for (int i = 0; i < count; i++) begin
         in_run = (i > run_from && i < run_from + run_len);
         if (i > 0 && !in_run && $urandom_range(0, 99) >= dup_pct)
            key = key + ({$urandom, $urandom} >> (stkr_pkg::KEY_W - step_bits)) + 1;
         mv = stkr_pkg::MOVE_W'($urandom);
         wt = stkr_pkg::WEIGHT_W'($urandom);
         if (!in_run) begin
            case ($urandom_range(0, 15))
               0: mv = '0;
               1: wt = '0;
               2: begin
                  mv = '0;
                  wt = '0;
               end
               default: ;
            endcase
         end
         plan_key[i] = key;
         queue_write(i, key, mv, wt, $urandom);
      end
   endtask

   function automatic logic [stkr_pkg::KEY_W-1:0] probe_key(input int count);
      int pick;
      int slot;
      pick = $urandom_range(0, 99);
      slot = $urandom_range(0, count - 1);
      if (pick < 60)
         return plan_key[slot];
      if (pick < 72)
         return plan_key[slot] + 1;
      if (pick < 80)
         return plan_key[slot] - 1;
      if (pick < 85)
         return plan_key[0] - 1;
      if (pick < 90)
         return plan_key[count - 1] + 1 + stkr_pkg::KEY_W'($urandom_range(0, 1000));
      if (pick < 94)
         return '0;
      return {$urandom, $urandom};
   endfunction

   task automatic run_random_phase(input int queries, input bit long_stall,
                                   input bit wide_table);
      int count;
      int cap_val;
      int run_len;
      int slot;
      count = wide_table ? $urandom_range(100, 110) : $urandom_range(1, 24);
      case ($urandom_range(0, 9))
         0: cap_val = 0;
         1: cap_val = $urandom_range(stkr_pkg::MAX_EMIT + 1, CAP_FIELD_MAX);
         2, 3: cap_val = $urandom_range(1, 3);
         default: cap_val = $urandom_range(1, stkr_pkg::MAX_EMIT);
      endcase
      run_len = wide_table ? RUN_SPAN : 0;
      write_csr(stkr_pkg::REG_TABLE_SIZE, stkr_pkg::CSR_DATA_W'(count));
      // upper data bits fall outside the cap field
      write_csr(stkr_pkg::REG_RESULT_CAP,
                {6'($urandom_range(0, 63)), stkr_pkg::CAP_W'(cap_val)});
      @(posedge clock);
      load_sorted_prefix(count, $urandom_range(10, 50), $urandom_range(1, 54),
                         $urandom_range(0, count / 3), run_len);
      for (int q = 0; q < queries; q++) begin
         if ($urandom_range(0, 19) == 0) begin
            // refresh an entry in place; the key stays, so the order holds
            slot = $urandom_range(0, count - 1);
            queue_write(slot, plan_key[slot], stkr_pkg::MOVE_W'($urandom),
                        stkr_pkg::WEIGHT_W'($urandom), $urandom);
         end
         queue_query(probe_key(count));
      end
      if (long_stall)
         stall_asks++;
      wait_idle();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // defaults: one slot in use, cap at its maximum
      set_pace(26, 58);
      queue_write(0, KEY_MAX, '1, '1, '1);
      queue_query(KEY_MAX);
      queue_query('0);
      queue_write(0, 64'd5, 16'd1, 16'd1, '0);
      queue_query(64'd6);
      queue_write(0, 64'd5, '0, 16'd9, 32'd1);
      queue_query(64'd5);
      queue_write(0, 64'd5, 16'd3, 16'd4, 32'd7);
      wait_idle();

      write_csr(stkr_pkg::REG_TABLE_SIZE, '0);
      @(posedge clock);
      queue_query(64'd5);
      wait_idle();

      write_csr(stkr_pkg::REG_TABLE_SIZE, stkr_pkg::CSR_DATA_W'(1));
      write_csr(stkr_pkg::REG_RESULT_CAP, '0);
      @(posedge clock);
      queue_query(64'd5);
      wait_idle();

      write_csr(REG_SPARE_2, '1);
      write_csr(REG_SPARE_3, '0);
      write_csr(stkr_pkg::REG_RESULT_CAP, {6'h3f, stkr_pkg::CAP_W'(2)});
      write_csr(stkr_pkg::REG_TABLE_SIZE, stkr_pkg::CSR_DATA_W'(8));
      @(posedge clock);
      queue_write(0, 64'd3, 16'h0101, 16'h0011, 32'h1000_0000);
      queue_write(1, 64'd3, 16'h0202, 16'h0022, 32'h2000_0000);
      queue_write(2, 64'd3, 16'h0303, 16'h0033, 32'h3000_0000);
      queue_write(3, 64'd7, 16'h0404, 16'h0044, 32'h4000_0000);
      queue_write(4, 64'd7, 16'h0505, '0, 32'h5000_0000);
      queue_write(5, 64'd7, 16'h0606, 16'h0066, 32'h6000_0000);
      queue_write(6, 64'd7, 16'h0707, 16'h0077, 32'h7000_0000);
      queue_write(7, 64'd9, 16'h0808, 16'h0088, 32'h8000_0000);
      queue_query(64'd7);
      queue_query(64'd3);
      wait_idle();

      write_csr(stkr_pkg::REG_RESULT_CAP, stkr_pkg::CSR_DATA_W'(CAP_FIELD_MAX));
      @(posedge clock);
      queue_query(64'd7);
      queue_query(64'd9);
      queue_query(64'd8);
      queue_query(64'd10);
      queue_query(64'd2);
      wait_idle();

      // right-hand search path of a full-size table: slots TABLE_DEPTH - 2**k
      @(posedge clock);
      for (int k = stkr_pkg::ADDR_W - 1; k >= 0; k--)
         queue_write(stkr_pkg::TABLE_DEPTH - (1 << k),
                     stkr_pkg::KEY_W'((stkr_pkg::ADDR_W - k) * SPINE_STEP),
                     16'h1111, 16'h2222, $urandom);
      wait_idle();

      write_csr(stkr_pkg::REG_TABLE_SIZE, stkr_pkg::CSR_DATA_W'(stkr_pkg::TABLE_DEPTH));
      write_csr(stkr_pkg::REG_RESULT_CAP, stkr_pkg::CSR_DATA_W'(stkr_pkg::MAX_EMIT));
      @(posedge clock);
      // the last slot matches; a key above it walks off the table end
      queue_query(stkr_pkg::KEY_W'(stkr_pkg::ADDR_W * SPINE_STEP));
      queue_query(stkr_pkg::KEY_W'(stkr_pkg::ADDR_W * SPINE_STEP + 1));
      wait_idle();

      // oversize table and cap saturate
      write_csr(stkr_pkg::REG_TABLE_SIZE, '1);
      write_csr(stkr_pkg::REG_RESULT_CAP, stkr_pkg::CSR_DATA_W'(CAP_FIELD_MAX));
      @(posedge clock);
      queue_query(stkr_pkg::KEY_W'(stkr_pkg::ADDR_W * SPINE_STEP));
      queue_query(stkr_pkg::KEY_W'(stkr_pkg::ADDR_W * SPINE_STEP + 1));
      wait_idle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 4)
            set_pace(58, 26);
         else if (p == 7)
            set_pace(0, 0);
         run_random_phase(PHASE_QUERIES, p == 1, p == 2 || p == 8);
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (!mismatch_seen)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
`default_nettype wire
